// ===== rtl/core/dsm_pkg.sv =====
`timescale 1ns / 1ps

package dsm_pkg;

    // Request kinds
    localparam logic [1:0] REQ_COMMAND = 2'd0;
    localparam logic [1:0] REQ_PULSE   = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    // Bridge direction codes
    localparam logic [1:0] DIR_OFF     = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STEP_SIZE   = 2'd0;
    localparam logic [1:0] CFG_COMMAND_ID  = 2'd1;
    localparam logic [1:0] CFG_SPEED_SCALE = 2'd2;

    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  STEP_SIZE_RESET   = 8'd2;
    localparam logic [10:0] COMMAND_ID_RESET  = 11'd262;
    localparam logic [15:0] SPEED_SCALE_RESET = 16'd41821;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] frame_id;
        logic [7:0]  fwd_byte;
        logic [7:0]  turn_minus_byte;
        logic [7:0]  turn_plus_byte;
    } req_t;

    typedef struct packed {
        logic [9:0]         left_duty;
        logic [9:0]         right_duty;
        logic [1:0]         left_dir;
        logic [1:0]         right_dir;
        logic               left_changed;
        logic               right_changed;
        logic signed [15:0] speed_feedback;
    } rsp_t;

    // Per-motor drive result between the mixer and the top level
    typedef struct packed {
        logic [9:0] duty;
        logic [1:0] dir;
        logic       changed;
    } motor_t;

endpackage

// ===== rtl/core/differential_drive_slew_mixer_unit.sv =====
`timescale 1ns / 1ps
// A control tick passes through the input register, then the result register;
// commands and pulses emit nothing.
// Throughput: one item per cycle; the result register holds under rsp_stall
// while commands and pulses keep flowing, a tick waits only for a free slot.
// Reset (rst_n, async low): all targets, current values, pulse delta and last
// duties go to zero; step_size 2, command_id 262, speed_scale 41821.

module differential_drive_slew_mixer_unit
    import dsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req_data,

    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp_data,

    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [7:0]  step_size_reg;
    logic [10:0] command_id_reg;
    logic [15:0] speed_scale_reg;

    // Input stage
    logic s1_valid_reg;
    req_t s1_item_reg;

    // Drive state. The pulse counter and its snapshot from the last tick are
    // folded into one running difference: it counts pulses since the last
    // tick and clears on each tick, which matches the wrapped subtraction.
    logic signed [7:0] target_fwd_reg;
    logic signed [8:0] target_turn_reg;
    logic signed [7:0] cur_fwd_reg;
    logic signed [8:0] cur_turn_reg;
    logic [31:0]       pulse_delta_reg;
    logic [9:0]        last_left_duty_reg;
    logic [9:0]        last_right_duty_reg;

    // Result register
    logic rsp_valid_reg;
    rsp_t rsp_data_reg;

    logic              req_accept;
    logic              s1_is_tick;
    logic              s1_advance;
    logic              cmd_hit;
    logic signed [7:0] cur_fwd_next;
    logic signed [8:0] cur_turn_next;
    logic signed [8:0] turn_target_new;
    motor_t            left_drive;
    motor_t            right_drive;
    logic signed [15:0] speed;

    // Move cur toward tgt by at most step; 11 bits cover cur +/- 255.
    function automatic logic signed [10:0] slew(
        input logic signed [10:0] cur,
        input logic signed [10:0] tgt,
        input logic [7:0]         step
    );
        logic signed [10:0] up;
        logic signed [10:0] dn;
        logic signed [10:0] r;
        up = cur + $signed({3'b000, step});
        dn = cur - $signed({3'b000, step});
        if (tgt > up)
            r = up;
        else if (tgt < dn)
            r = dn;
        else
            r = tgt;
        return r;
    endfunction

    // A tick needs the result slot; anything else always retires.
    assign s1_is_tick = (s1_item_reg.req_type == REQ_TICK);
    assign s1_advance = s1_valid_reg && (!s1_is_tick || !rsp_valid_reg || !rsp_stall);
    assign req_stall  = s1_valid_reg && !s1_advance;
    assign req_accept = req_valid && !req_stall;

    assign cmd_hit = (s1_item_reg.frame_id == command_id_reg);
    assign turn_target_new = $signed({s1_item_reg.turn_plus_byte[7], s1_item_reg.turn_plus_byte})
                           - $signed({s1_item_reg.turn_minus_byte[7],
                                      s1_item_reg.turn_minus_byte});

    // Result always stays within the target's range, so truncation is exact.
    assign cur_fwd_next  = 8'(slew(11'(cur_fwd_reg), 11'(target_fwd_reg), step_size_reg));
    assign cur_turn_next = 9'(slew(11'(cur_turn_reg), 11'(target_turn_reg), step_size_reg));

    dsm_mix u_mix (
        .cur_fwd         (cur_fwd_next),
        .cur_turn        (cur_turn_next),
        .last_left_duty  (last_left_duty_reg),
        .last_right_duty (last_right_duty_reg),
        .left            (left_drive),
        .right           (right_drive)
    );

    dsm_speed u_speed (
        .pulse_delta (pulse_delta_reg),
        .speed_scale (speed_scale_reg),
        .speed       (speed)
    );

    // Configuration writes; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg   <= STEP_SIZE_RESET;
            command_id_reg  <= COMMAND_ID_RESET;
            speed_scale_reg <= SPEED_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_SIZE:   step_size_reg   <= cfg_data[7:0];
                CFG_COMMAND_ID:  command_id_reg  <= cfg_data[10:0];
                CFG_SPEED_SCALE: speed_scale_reg <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // Input register: loads on every transfer, empties when the item retires.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!req_stall)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
            s1_item_reg <= req_data;
    end

    // Drive state update as the stage-one item retires, in arrival order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_fwd_reg      <= '0;
            target_turn_reg     <= '0;
            cur_fwd_reg         <= '0;
            cur_turn_reg        <= '0;
            pulse_delta_reg     <= '0;
            last_left_duty_reg  <= '0;
            last_right_duty_reg <= '0;
        end
        else if (s1_advance)
        begin
            case (s1_item_reg.req_type)
                REQ_COMMAND:
                begin
                    if (cmd_hit)
                    begin
                        target_fwd_reg  <= $signed(s1_item_reg.fwd_byte);
                        target_turn_reg <= turn_target_new;
                    end
                end
                REQ_PULSE:
                begin
                    if (target_fwd_reg[7])
                        pulse_delta_reg <= pulse_delta_reg - 32'd1;
                    else
                        pulse_delta_reg <= pulse_delta_reg + 32'd1;
                end
                REQ_TICK:
                begin
                    cur_fwd_reg         <= cur_fwd_next;
                    cur_turn_reg        <= cur_turn_next;
                    pulse_delta_reg     <= '0;
                    last_left_duty_reg  <= left_drive.duty;
                    last_right_duty_reg <= right_drive.duty;
                end
                default: ;  // unused request kind: no effect
            endcase
        end
    end

    // Result register: filled by a retiring tick, cleared when transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (s1_advance && s1_is_tick)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_is_tick)
        begin
            rsp_data_reg.left_duty      <= left_drive.duty;
            rsp_data_reg.right_duty     <= right_drive.duty;
            rsp_data_reg.left_dir       <= left_drive.dir;
            rsp_data_reg.right_dir      <= right_drive.dir;
            rsp_data_reg.left_changed   <= left_drive.changed;
            rsp_data_reg.right_changed  <= right_drive.changed;
            rsp_data_reg.speed_feedback <= speed;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ===== rtl/core/dsm_mix.sv =====
`timescale 1ns / 1ps

module dsm_mix
    import dsm_pkg::*;
(
    input  logic signed [7:0] cur_fwd,
    input  logic signed [8:0] cur_turn,
    input  logic [9:0]        last_left_duty,
    input  logic [9:0]        last_right_duty,
    output motor_t            left,
    output motor_t            right
);

    logic signed [10:0] left_sum;
    logic signed [10:0] right_sum;
    logic signed [7:0]  left_clamped;
    logic signed [7:0]  right_clamped;

    function automatic logic signed [7:0] clamp100(input logic signed [10:0] x);
        logic signed [7:0] r;
        if (x < -11'sd100)
            r = -8'sd100;
        else if (x > 11'sd100)
            r = 8'sd100;
        else
            r = x[7:0];
        return r;
    endfunction

    function automatic motor_t drive(input logic signed [7:0] v, input logic [9:0] last);
        motor_t     m;
        logic [6:0] mag;
        mag = v[7] ? 7'(-v) : v[6:0];
        // |v| * 10 as shift-add
        m.duty = {mag, 3'b000} + {2'b00, mag, 1'b0};
        if (v > 8'sd0)
            m.dir = DIR_FORWARD;
        else if (v < 8'sd0)
            m.dir = DIR_REVERSE;
        else
            m.dir = DIR_OFF;
        m.changed = (m.duty != last);
        return m;
    endfunction

    assign left_sum      = 11'(cur_fwd) + 11'(cur_turn);
    assign right_sum     = 11'(cur_fwd) - 11'(cur_turn);
    assign left_clamped  = clamp100(left_sum);
    assign right_clamped = clamp100(right_sum);
    assign left          = drive(left_clamped, last_left_duty);
    assign right         = drive(right_clamped, last_right_duty);

endmodule

// ===== rtl/core/dsm_speed.sv =====
`timescale 1ns / 1ps

module dsm_speed
    import dsm_pkg::*;
(
    input  logic [31:0]        pulse_delta,
    input  logic [15:0]        speed_scale,
    output logic signed [15:0] speed
);

    logic        neg;
    logic [31:0] mag;
    logic [47:0] prod;
    logic [31:0] quot;

    assign neg  = pulse_delta[31];
    assign mag  = neg ? (32'd0 - pulse_delta) : pulse_delta;
    assign prod = 48'(mag) * 48'(speed_scale);
    assign quot = prod[47:16];

    // Truncate toward zero on the magnitude, then saturate to int16
    always_comb
    begin
        if (neg)
            speed = (quot > 32'd32768) ? -16'sd32768 : 16'(32'd0 - quot);
        else
            speed = (quot > 32'd32767) ? 16'sd32767 : 16'(quot);
    end

endmodule
